// ===== rtl/utu_pkg.sv =====
// utu_pkg: shared types, constants and the utf-8 encoder function
// for the utf16 to utf8 transcoder; no dependencies
`timescale 1ns / 1ps

package utu_pkg;

  localparam int unsigned CountW     = 13;
  localparam int unsigned UnitW      = 16;
  localparam int unsigned HardLimit  = 4096;
  localparam int unsigned CountMax   = 8191;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxBytes   = 4;
  localparam int unsigned NbW        = 3;

  // register byte offsets
  localparam logic [2:0] AddrMaxUnits = 3'd0;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_e;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [NbW-1:0]           nb;
  } enc_t;

  // one queue entry: the bytes of one code point and the string close
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [NbW-1:0]           nb;
    logic                     str_end;
    status_e                  status;
  } cmd_t;

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp <= 21'h7F) begin
      e.bytes[0] = cp[7:0];
      e.nb       = NbW'(1);
    end else if (cp <= 21'h7FF) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.nb       = NbW'(2);
    end else if (cp <= 21'hFFFF) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.nb       = NbW'(3);
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.nb       = NbW'(4);
    end
    return e;
  endfunction

endpackage

// ===== rtl/utu_front.sv =====
// utu_front: accepts code units, tracks surrogates, length and errors,
// and pushes byte/close commands; depends on utu_pkg
`timescale 1ns / 1ps

module utu_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [utu_pkg::CountW-1:0]     max_units_i,
  input  logic [utu_pkg::UnitW-1:0]      code_unit_i,
  input  logic                           string_end_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output utu_pkg::cmd_t                  q_cmd_o
);

  logic [9:0]                   pend_high_q, pend_high_d;
  logic                         pend_valid_q, pend_valid_d;
  logic [utu_pkg::CountW-1:0]   count_q, count_d, count_inc, limit;
  utu_pkg::status_e             err_q, err_d, err_len;
  logic                         is_high, is_low, use_enc, accept;
  logic [20:0]                  cp;
  utu_pkg::enc_t                enc;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign limit = (max_units_i > utu_pkg::CountW'(utu_pkg::HardLimit)) ?
                 utu_pkg::CountW'(utu_pkg::HardLimit) : max_units_i;
  assign count_inc = (count_q != utu_pkg::CountW'(utu_pkg::CountMax)) ?
                     count_q + utu_pkg::CountW'(1) : count_q;
  assign err_len = (count_inc > limit) ? utu_pkg::STATUS_TOO_LONG : err_q;

  assign is_high = (code_unit_i[15:10] == 6'b110110);
  assign is_low  = (code_unit_i[15:10] == 6'b110111);

  // surrogate pair joins into a supplementary code point
  assign cp  = pend_valid_q ? 21'h10000 + {1'b0, pend_high_q, code_unit_i[9:0]}
                            : {5'd0, code_unit_i};
  assign enc = utu_pkg::utf8_encode(cp);

  always_comb begin
    pend_high_d  = pend_high_q;
    pend_valid_d = pend_valid_q;
    err_d        = err_len;
    use_enc      = 1'b0;
    if (err_len != utu_pkg::STATUS_OK) begin
      pend_valid_d = 1'b0;
    end else if (pend_valid_q) begin
      pend_valid_d = 1'b0;
      if (is_low) begin
        use_enc = 1'b1;
      end else begin
        err_d = utu_pkg::STATUS_INVALID;
      end
    end else if (is_high) begin
      if (string_end_i) begin
        err_d = utu_pkg::STATUS_INVALID;
      end else begin
        pend_high_d  = code_unit_i[9:0];
        pend_valid_d = 1'b1;
      end
    end else if (is_low || code_unit_i == '0) begin
      err_d = utu_pkg::STATUS_INVALID;
    end else begin
      use_enc = 1'b1;
    end
    count_d = count_inc;
    // string close clears the per-string state
    if (string_end_i) begin
      pend_valid_d = 1'b0;
      pend_high_d  = '0;
      count_d      = '0;
    end
  end

  always_comb begin
    q_cmd_o.bytes   = enc.bytes;
    q_cmd_o.nb      = use_enc ? enc.nb : '0;
    q_cmd_o.str_end = string_end_i;
    q_cmd_o.status  = err_d;
  end

  assign q_push_o = accept && (use_enc || string_end_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_high_q  <= '0;
      pend_valid_q <= 1'b0;
      count_q      <= '0;
      err_q        <= utu_pkg::STATUS_OK;
    end else if (accept) begin
      pend_high_q  <= pend_high_d;
      pend_valid_q <= pend_valid_d;
      count_q      <= count_d;
      err_q        <= string_end_i ? utu_pkg::STATUS_OK : err_d;
    end
  end

endmodule

// ===== rtl/utu_queue.sv =====
// utu_queue: small command fifo between front and back end
// depends on utu_pkg
`timescale 1ns / 1ps

module utu_queue #(
  parameter int unsigned Depth = utu_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  utu_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output utu_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  utu_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/utu_back.sv =====
// utu_back: walks each command one result per cycle into the output register,
// unless out_ready_i stalls it; depends on utu_pkg
`timescale 1ns / 1ps

module utu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  utu_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic [7:0]    data_byte_o,
  output logic          has_byte_o,
  output logic          run_last_o,
  output logic          string_done_o,
  output logic [1:0]    string_status_o,
  output logic          out_valid_o,
  input  logic          out_ready_i
);

  logic [utu_pkg::NbW-1:0] idx_q;
  logic                    valid_q, load, is_byte, last_byte;
  logic [7:0]              byte_q;
  logic                    has_q, last_q, done_q;
  utu_pkg::status_e        status_q;

  assign load      = !q_empty_i && (!valid_q || out_ready_i);
  assign is_byte   = (idx_q < q_cmd_i.nb);
  assign last_byte = (idx_q == q_cmd_i.nb - utu_pkg::NbW'(1));
  // entry is done after its last byte, or after the status when it closes a string
  assign q_pop_o   = load && (is_byte ? (last_byte && !q_cmd_i.str_end) : 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= q_pop_o ? '0 : idx_q + utu_pkg::NbW'(1);
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (is_byte) begin
        byte_q   <= q_cmd_i.bytes[idx_q[1:0]];
        has_q    <= 1'b1;
        last_q   <= last_byte && !q_cmd_i.str_end;
        done_q   <= 1'b0;
        status_q <= utu_pkg::STATUS_OK;
      end else begin
        byte_q   <= '0;
        has_q    <= 1'b0;
        last_q   <= 1'b1;
        done_q   <= 1'b1;
        status_q <= q_cmd_i.status;
      end
    end
  end

  assign out_valid_o     = valid_q;
  assign data_byte_o     = byte_q;
  assign has_byte_o      = has_q;
  assign run_last_o      = last_q;
  assign string_done_o   = done_q;
  assign string_status_o = status_q;

endmodule

// ===== rtl/utf16_to_utf8_transcoder.sv =====
// utf16_to_utf8_transcoder: top level, config register, front end, queue, back end
// depends on utu_pkg, utu_front, utu_queue, utu_back
//
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid_i/in_ready_o | code_unit_i, string_end_i
// output   | out_valid_o/out_ready_i | data_byte_o, has_byte_o, run_last_o,
//          |                       | string_done_o, string_status_o
// config   | psel/penable/pwrite   | paddr, pwdata, prdata (max_units at 0x0)
//
// the front end takes one code unit per cycle while the command queue has room
// the back end sends one result per cycle unless out_ready_i stalls it, so each
// unit gives the utf-8 bytes it completes, plus a status when it closes a string
// a result passes through the queue memory and then the output register
// reset clears string state and sets max_units to 4096; either side may stall
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder #(
  parameter int unsigned QueueDepth = utu_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic [15:0] code_unit_i,
  input  logic        string_end_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [7:0]  data_byte_o,
  output logic        has_byte_o,
  output logic        run_last_o,
  output logic        string_done_o,
  output logic [1:0]  string_status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  logic [utu_pkg::CountW-1:0] max_units_q;
  logic                       q_full, q_empty, q_push, q_pop, sel_max;
  utu_pkg::cmd_t              push_cmd, head_cmd;

  assign pready  = 1'b1;
  assign sel_max = (paddr[2] == utu_pkg::AddrMaxUnits[2]);
  assign prdata  = sel_max ? {{(32 - utu_pkg::CountW){1'b0}}, max_units_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= utu_pkg::CountW'(utu_pkg::HardLimit);
    end else if (psel && penable && pwrite && sel_max) begin
      max_units_q <= pwdata[utu_pkg::CountW-1:0];
    end
  end

  utu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_units_i  (max_units_q),
    .code_unit_i  (code_unit_i),
    .string_end_i (string_end_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (push_cmd)
  );

  utu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  utu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_cmd_i         (head_cmd),
    .q_pop_o         (q_pop),
    .data_byte_o     (data_byte_o),
    .has_byte_o      (has_byte_o),
    .run_last_o      (run_last_o),
    .string_done_o   (string_done_o),
    .string_status_o (string_status_o),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i)
  );

endmodule
